// ===== hdl/vector3_alu_macros.svh =====
// ----------------------------------------------------------------------------
// Vector3 ALU assertion macros
// Shared property wrappers for the vector ALU. They compile to nothing in
// synthesis builds.
// ----------------------------------------------------------------------------
`ifndef VECTOR3_ALU_MACROS_SVH
`define VECTOR3_ALU_MACROS_SVH
`ifndef SYNTHESIS
`define V3_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define V3_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define V3_ASSERT_IMPL(label, ante, cons, msg)
`define V3_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== hdl/v3alu_pkg.sv =====
// ----------------------------------------------------------------------------
// Vector3 ALU package
// Opcodes, pipeline payload types and the per-step arithmetic helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package v3alu_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int NUM_W         = 96;
	localparam int SQ_STEPS      = 32;
	localparam int DIV_STEPS     = 32;

	typedef enum logic [3:0] {
		OP_ADD   = 4'd0,
		OP_SUB   = 4'd1,
		OP_SCALE = 4'd2,
		OP_DIV   = 4'd3,
		OP_DOT   = 4'd4,
		OP_CROSS = 4'd5,
		OP_MAG   = 4'd6,
		OP_NORM  = 4'd7,
		OP_PROJS = 4'd8,
		OP_PROJV = 4'd9
	} opcode_t;

	typedef struct packed {
		logic        sat;
		logic [31:0] val;
	} satv_t;

	typedef struct packed {
		logic [3:0]       op;
		logic             zero;
		logic             rsat;
		logic [2:0][31:0] res;
		logic [31:0]      rsc;
		logic [63:0]      rad;
		logic [63:0]      dabs;
		logic             dneg;
		logic [2:0][31:0] aabs;
		logic [2:0]       aneg;
		logic [2:0][31:0] babs;
		logic [2:0]       bneg;
		logic [31:0]      sabs;
		logic             sneg;
		logic [63:0]      sb;
	} pre_t;

	typedef struct packed {
		logic [3:0]            op;
		logic                  zero;
		logic                  rsat;
		logic [2:0][31:0]      res;
		logic [31:0]           rsc;
		logic [2:0][NUM_W-1:0] num;
		logic [2:0]            neg;
		logic [63:0]           dvs;
		logic                  useroot;
	} pay_t;

	typedef struct packed {
		logic [33:0] rem;
		logic [31:0] root;
		logic [63:0] rad;
	} sq_t;

	typedef struct packed {
		logic [63:0] rem;
		logic [31:0] q;
		logic        ovf;
	} dl_t;

	typedef struct packed {
		logic [3:0]       op;
		logic             zero;
		logic             rsat;
		logic [2:0][31:0] res;
		logic [31:0]      rsc;
		logic [2:0]       neg;
		logic [63:0]      dvs;
		dl_t [2:0]        ln;
	} dp_t;

	typedef struct packed {
		logic [2:0][31:0] vec;
		logic [31:0]      sc;
		logic             zero;
		logic             sat;
	} fin_t;

	// Clip a wide signed value to 32 bits.
	function automatic satv_t sat32(input logic signed [127:0] v);
		satv_t r;
		if (v > 128'sd2147483647) begin
			r.sat = 1'b1;
			r.val = 32'h7FFF_FFFF;
		end else if (v < -128'sd2147483648) begin
			r.sat = 1'b1;
			r.val = 32'h8000_0000;
		end else begin
			r.sat = 1'b0;
			r.val = v[31:0];
		end
		return r;
	endfunction

	// Apply the sign to a quotient magnitude and clip it.
	function automatic satv_t quo_fix(input logic [31:0] q, input logic ovf, input logic neg);
		satv_t r;
		if (!neg) begin
			if (ovf || q[31]) begin
				r.sat = 1'b1;
				r.val = 32'h7FFF_FFFF;
			end else begin
				r.sat = 1'b0;
				r.val = q;
			end
		end else begin
			if (ovf || (q[31] && (q[30:0] != 31'd0))) begin
				r.sat = 1'b1;
				r.val = 32'h8000_0000;
			end else begin
				r.sat = 1'b0;
				r.val = ~q + 32'd1;
			end
		end
		return r;
	endfunction

	// One digit of the restoring square root.
	function automatic sq_t sq_step(input sq_t x);
		logic [35:0] tmp;
		logic [35:0] trial;
		sq_t r;
		tmp   = {x.rem, x.rad[63:62]};
		trial = {2'b00, x.root, 2'b01};
		r.rad = {x.rad[61:0], 2'b00};
		if (tmp >= trial) begin
			r.rem  = 34'(tmp - trial);
			r.root = {x.root[30:0], 1'b1};
		end else begin
			r.rem  = 34'(tmp);
			r.root = {x.root[30:0], 1'b0};
		end
		return r;
	endfunction

	// One quotient bit of the restoring divider on every lane.
	function automatic dp_t dv_step(input dp_t x);
		logic [64:0] tmp;
		dp_t r;
		r = x;
		for (int j = 0; j < 3; j++) begin
			tmp = {x.ln[j].rem, x.ln[j].q[31]};
			if (tmp >= {1'b0, x.dvs}) begin
				r.ln[j].rem = 64'(tmp - {1'b0, x.dvs});
				r.ln[j].q   = {x.ln[j].q[30:0], 1'b1};
			end else begin
				r.ln[j].rem = tmp[63:0];
				r.ln[j].q   = {x.ln[j].q[30:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/vector3_alu.sv =====
// ----------------------------------------------------------------------------
// Vector3 ALU
// Pipelined Q-format arithmetic on three-component vectors: add, subtract,
// scale, divide, dot, cross, magnitude, normalize and both projections.
//
// Usage: the input channel (in_valid/in_stall) carries one request of opcode,
// vectors a and b and a scalar; the output channel (out_valid/out_stall)
// returns one result per request, in order, with zero_divisor and saturated.
// Stages from the accepting edge to out_valid: six operand and multiply
// stages, 32 square root stages (one root bit each), one divisor setup stage,
// 32 divider stages (one quotient bit each) and the output register. A new
// request is taken every cycle unless the output stalls, so throughput is one
// request per clock while out_stall is low.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall is raised in the same cycle; nothing is dropped or repeated.
// Reset clears all valid bits; the block takes requests right after reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "vector3_alu_macros.svh"

module vector3_alu
	import v3alu_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [3:0]         opcode,
	input  logic signed [31:0] ax,
	input  logic signed [31:0] ay,
	input  logic signed [31:0] az,
	input  logic signed [31:0] bx,
	input  logic signed [31:0] by,
	input  logic signed [31:0] bz,
	input  logic signed [31:0] scalar_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] rx,
	output logic signed [31:0] ry,
	output logic signed [31:0] rz,
	output logic signed [31:0] scalar_out,
	output logic               zero_divisor,
	output logic               saturated
);

	localparam int NST = 6 + SQ_STEPS + 1 + DIV_STEPS + 1;

	logic           en;
	logic [NST:1]   v_q;

	logic [3:0]         op_s1;
	logic signed [31:0] a_s1 [3];
	logic signed [31:0] b_s1 [3];
	logic signed [31:0] s_s1;

	logic signed [31:0] mx [6];
	logic signed [31:0] my [6];

	logic [3:0]         op_s2;
	logic signed [63:0] p_s2 [6];
	logic signed [32:0] as_s2 [3];
	logic signed [31:0] a_s2 [3];
	logic signed [31:0] b_s2 [3];
	logic signed [31:0] s_s2;

	logic [3:0]         op_s3;
	logic signed [65:0] sa_s3;
	logic signed [65:0] sb_s3;
	logic signed [64:0] cr_s3 [3];
	logic signed [63:0] pc_s3 [3];
	logic signed [32:0] as_s3 [3];
	logic signed [31:0] a_s3 [3];
	logic signed [31:0] b_s3 [3];
	logic signed [31:0] s_s3;

	pre_t  pr_c;
	satv_t st_c;
	pre_t  pr_s4;

	pre_t             pr_s5;
	logic [2:0][63:0] mlo_s5;
	logic [2:0][63:0] mhi_s5;

	pay_t py_c;
	pay_t py_s [SQ_STEPS+1];
	sq_t  sq_s [SQ_STEPS+1];

	dp_t   dz_c;
	satv_t mg_c;
	dp_t   dv_s [DIV_STEPS+1];

	satv_t fx_c [3];
	fin_t  fin_c;
	fin_t  res_sl;

	assign en        = !(v_q[NST] && out_stall);
	assign in_stall  = !en;
	assign out_valid = v_q[NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[NST-1:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1   <= opcode;
			a_s1[0] <= ax;
			a_s1[1] <= ay;
			a_s1[2] <= az;
			b_s1[0] <= bx;
			b_s1[1] <= by;
			b_s1[2] <= bz;
			s_s1    <= scalar_in;
		end
	end

	// Operand routing for the six shared multipliers.
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			mx[j]   = a_s1[j];
			my[j]   = b_s1[j];
			mx[j+3] = b_s1[j];
			my[j+3] = b_s1[j];
		end
		unique case (op_s1) inside
			OP_SCALE: begin
				for (int j = 0; j < 3; j++) my[j] = s_s1;
			end
			OP_MAG, OP_NORM: begin
				for (int j = 0; j < 3; j++) my[j] = a_s1[j];
			end
			OP_CROSS: begin
				mx[0] = a_s1[1]; my[0] = b_s1[2];
				mx[1] = a_s1[2]; my[1] = b_s1[1];
				mx[2] = a_s1[2]; my[2] = b_s1[0];
				mx[3] = a_s1[0]; my[3] = b_s1[2];
				mx[4] = a_s1[0]; my[4] = b_s1[1];
				mx[5] = a_s1[1]; my[5] = b_s1[0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2 <= op_s1;
			s_s2  <= s_s1;
			for (int j = 0; j < 6; j++) p_s2[j] <= mx[j] * my[j];
			for (int j = 0; j < 3; j++) begin
				as_s2[j] <= (op_s1 == OP_SUB) ? (33'(a_s1[j]) - 33'(b_s1[j]))
				                              : (33'(a_s1[j]) + 33'(b_s1[j]));
				a_s2[j]  <= a_s1[j];
				b_s2[j]  <= b_s1[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s3 <= op_s2;
			s_s3  <= s_s2;
			sa_s3 <= 66'(p_s2[0]) + 66'(p_s2[1]) + 66'(p_s2[2]);
			sb_s3 <= 66'(p_s2[3]) + 66'(p_s2[4]) + 66'(p_s2[5]);
			for (int j = 0; j < 3; j++) begin
				cr_s3[j] <= 65'(p_s2[2*j]) - 65'(p_s2[2*j+1]);
				pc_s3[j] <= p_s2[j];
				as_s3[j] <= as_s2[j];
				a_s3[j]  <= a_s2[j];
				b_s3[j]  <= b_s2[j];
			end
		end
	end

	// Direct results, zero checks and operand magnitudes.
	always_comb begin
		pr_c      = '0;
		st_c      = '0;
		pr_c.op   = op_s3;
		pr_c.zero = ((op_s3 == OP_DIV) && (s_s3 == 32'sd0)) ||
		            (((op_s3 == OP_MAG) || (op_s3 == OP_NORM)) && (sa_s3 == 66'sd0)) ||
		            (((op_s3 == OP_PROJS) || (op_s3 == OP_PROJV)) && (sb_s3 == 66'sd0));
		pr_c.rad  = ((op_s3 == OP_PROJS) || (op_s3 == OP_PROJV)) ? sb_s3[63:0] : sa_s3[63:0];
		pr_c.dabs = sa_s3[65] ? 64'(-sa_s3) : sa_s3[63:0];
		pr_c.dneg = sa_s3[65];
		pr_c.sabs = s_s3[31] ? 32'(-33'(s_s3)) : s_s3;
		pr_c.sneg = s_s3[31];
		pr_c.sb   = sb_s3[63:0];
		for (int j = 0; j < 3; j++) begin
			pr_c.aabs[j] = a_s3[j][31] ? 32'(-33'(a_s3[j])) : a_s3[j];
			pr_c.aneg[j] = a_s3[j][31];
			pr_c.babs[j] = b_s3[j][31] ? 32'(-33'(b_s3[j])) : b_s3[j];
			pr_c.bneg[j] = b_s3[j][31];
		end
		unique case (op_s3) inside
			OP_ADD, OP_SUB: begin
				for (int j = 0; j < 3; j++) begin
					st_c           = sat32(128'(as_s3[j]));
					pr_c.res[j]    = st_c.val;
					pr_c.rsat      = pr_c.rsat | st_c.sat;
				end
			end
			OP_SCALE: begin
				for (int j = 0; j < 3; j++) begin
					st_c           = sat32(128'(pc_s3[j]) >>> FRAC_BITS);
					pr_c.res[j]    = st_c.val;
					pr_c.rsat      = pr_c.rsat | st_c.sat;
				end
			end
			OP_CROSS: begin
				for (int j = 0; j < 3; j++) begin
					st_c           = sat32(128'(cr_s3[j]) >>> FRAC_BITS);
					pr_c.res[j]    = st_c.val;
					pr_c.rsat      = pr_c.rsat | st_c.sat;
				end
			end
			OP_DOT: begin
				st_c      = sat32(128'(sa_s3) >>> FRAC_BITS);
				pr_c.rsc  = st_c.val;
				pr_c.rsat = st_c.sat;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pr_s4 <= pr_c;
		end
	end

	// The dot product times each b component, in two 32-bit halves.
	always_ff @(posedge clk) begin
		if (en) begin
			pr_s5 <= pr_s4;
			for (int j = 0; j < 3; j++) begin
				mlo_s5[j] <= pr_s4.dabs[31:0] * pr_s4.babs[j];
				mhi_s5[j] <= pr_s4.dabs[63:32] * pr_s4.babs[j];
			end
		end
	end

	// Dividend magnitudes, quotient signs and the divisor.
	always_comb begin
		py_c      = '0;
		py_c.op   = pr_s5.op;
		py_c.zero = pr_s5.zero;
		py_c.rsat = pr_s5.rsat;
		py_c.res  = pr_s5.res;
		py_c.rsc  = pr_s5.rsc;
		unique case (pr_s5.op) inside
			OP_DIV: begin
				for (int j = 0; j < 3; j++) begin
					py_c.num[j] = NUM_W'(pr_s5.aabs[j]) << FRAC_BITS;
					py_c.neg[j] = pr_s5.aneg[j] ^ pr_s5.sneg;
				end
				py_c.dvs = 64'(pr_s5.sabs);
			end
			OP_NORM: begin
				for (int j = 0; j < 3; j++) begin
					py_c.num[j] = NUM_W'(pr_s5.aabs[j]) << FRAC_BITS;
					py_c.neg[j] = pr_s5.aneg[j];
				end
				py_c.useroot = 1'b1;
			end
			OP_PROJS: begin
				py_c.num[0]  = NUM_W'(pr_s5.dabs);
				py_c.neg[0]  = pr_s5.dneg;
				py_c.useroot = 1'b1;
			end
			OP_PROJV: begin
				for (int j = 0; j < 3; j++) begin
					py_c.num[j] = NUM_W'(mlo_s5[j]) + (NUM_W'(mhi_s5[j]) << 32);
					py_c.neg[j] = pr_s5.dneg ^ pr_s5.bneg[j];
				end
				py_c.dvs = pr_s5.sb;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			py_s[0] <= py_c;
			sq_s[0] <= '{rem: '0, root: '0, rad: pr_s5.rad};
		end
	end

	for (genvar k = 1; k <= SQ_STEPS; k++) begin : g_sqrt
		always_ff @(posedge clk) begin
			if (en) begin
				py_s[k] <= py_s[k-1];
				sq_s[k] <= sq_step(sq_s[k-1]);
			end
		end
	end

	// Divisor select, quotient range check and the magnitude result.
	always_comb begin
		dz_c      = '0;
		dz_c.op   = py_s[SQ_STEPS].op;
		dz_c.zero = py_s[SQ_STEPS].zero;
		dz_c.rsat = py_s[SQ_STEPS].rsat;
		dz_c.res  = py_s[SQ_STEPS].res;
		dz_c.rsc  = py_s[SQ_STEPS].rsc;
		dz_c.neg  = py_s[SQ_STEPS].neg;
		dz_c.dvs  = py_s[SQ_STEPS].useroot ? {32'd0, sq_s[SQ_STEPS].root}
		                                   : py_s[SQ_STEPS].dvs;
		for (int j = 0; j < 3; j++) begin
			dz_c.ln[j].rem = py_s[SQ_STEPS].num[j][NUM_W-1:32];
			dz_c.ln[j].q   = py_s[SQ_STEPS].num[j][31:0];
			dz_c.ln[j].ovf = py_s[SQ_STEPS].num[j][NUM_W-1:32] >= dz_c.dvs;
		end
		mg_c = sat32({96'd0, sq_s[SQ_STEPS].root});
		if (py_s[SQ_STEPS].op == OP_MAG) begin
			dz_c.rsc  = mg_c.val;
			dz_c.rsat = mg_c.sat;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0] <= dz_c;
		end
	end

	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[k] <= dv_step(dv_s[k-1]);
			end
		end
	end

	// Result selection.
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			fx_c[j] = quo_fix(dv_s[DIV_STEPS].ln[j].q, dv_s[DIV_STEPS].ln[j].ovf,
			                  dv_s[DIV_STEPS].neg[j]);
		end
		fin_c.vec  = dv_s[DIV_STEPS].res;
		fin_c.sc   = dv_s[DIV_STEPS].rsc;
		fin_c.sat  = dv_s[DIV_STEPS].rsat;
		fin_c.zero = dv_s[DIV_STEPS].zero;
		if (dv_s[DIV_STEPS].zero) begin
			fin_c.vec = '0;
			fin_c.sc  = '0;
			fin_c.sat = 1'b0;
		end else begin
			unique case (dv_s[DIV_STEPS].op) inside
				OP_DIV, OP_NORM, OP_PROJV: begin
					for (int j = 0; j < 3; j++) fin_c.vec[j] = fx_c[j].val;
					fin_c.sc  = '0;
					fin_c.sat = fx_c[0].sat | fx_c[1].sat | fx_c[2].sat;
				end
				OP_PROJS: begin
					fin_c.vec = '0;
					fin_c.sc  = fx_c[0].val;
					fin_c.sat = fx_c[0].sat;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_sl <= fin_c;
		end
	end

	assign rx           = res_sl.vec[0];
	assign ry           = res_sl.vec[1];
	assign rz           = res_sl.vec[2];
	assign scalar_out   = res_sl.sc;
	assign zero_divisor = res_sl.zero;
	assign saturated    = res_sl.sat;

	`V3_ASSERT_IMPL(a_zero_clean, out_valid && zero_divisor, !saturated && rx == 32'sd0 && ry == 32'sd0 && rz == 32'sd0 && scalar_out == 32'sd0, "zero divisor result carries nonzero fields")
	`V3_ASSERT_NEXT(a_no_loss, v_q[NST-1] && !in_stall, out_valid, "request lost before the output register")
	`V3_ASSERT_NEXT(a_no_invent, !v_q[NST-1] && !out_stall, !out_valid, "result appeared without a request")

endmodule

`default_nettype wire
